// ===== rtl/core/assoc_writeback_lru_cache_core_defines.svh =====
// assertion macros for the cache core
`ifndef ASSOC_WRITEBACK_LRU_CACHE_CORE_DEFINES_SVH
`define ASSOC_WRITEBACK_LRU_CACHE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define AWC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AWC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define AWC_ASSERT(label, clk, rst_n, prop, msg)
`define AWC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/core/awc_pkg.sv =====
// shared types and constants of the cache core
package awc_pkg;
  localparam int unsigned NumLines     = 5;
  localparam int unsigned WordsPerLine = 10;
  localparam int unsigned MemWords     = 128;
  localparam int unsigned WordW        = 15;
  localparam int unsigned AddrW        = 8;
  localparam int unsigned MemAw        = $clog2(MemWords);
  localparam int unsigned TagW         = 4;
  localparam int unsigned OffW         = $clog2(WordsPerLine);
  localparam int unsigned LineW        = $clog2(NumLines);
  localparam int unsigned RankW        = 3;
  localparam int unsigned CntW         = $clog2(WordsPerLine + 1);
  localparam int unsigned LwAw         = $clog2(NumLines * WordsPerLine);
  localparam int unsigned DelayW       = 4;

  // line number by reciprocal multiply: (a * 205) >> 11 equals a / 10 for a below 128
  localparam int unsigned TagRecip = 205;
  localparam int unsigned TagShift = 11;
  localparam int unsigned ProdW    = MemAw + 8;

  localparam logic [1:0] OpRead   = 2'd0;
  localparam logic [1:0] OpWrite  = 2'd1;
  localparam logic [1:0] OpFlush  = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [DelayW-1:0] HitDelay  = 4'd2;
  localparam logic [DelayW-1:0] MissDelay = 4'd10;

  typedef struct packed {
    logic [1:0]       operation;
    logic [AddrW-1:0] address;
    logic [WordW-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [WordW-1:0]  read_data;
    logic              hit;
    logic              out_of_range;
    logic [DelayW-1:0] delay;
  } rsp_t;

  // request from the controller to the word mover
  typedef struct packed {
    logic             start;
    logic             to_mem;   // 1: line to backing memory, 0: fill
    logic [LineW-1:0] line;
    logic [TagW-1:0]  tag;
  } move_t;

  // words actually held by a line of this tag (last line is partial)
  function automatic logic [CntW-1:0] words_in_line(logic [TagW-1:0] tag);
    int unsigned base;
    base = int'(tag) * WordsPerLine;
    if (base >= MemWords) return '0;
    if (MemWords - base < WordsPerLine) return CntW'(MemWords - base);
    return CntW'(WordsPerLine);
  endfunction
endpackage

// ===== rtl/core/awc_if.sv =====
// valid/ready channel carrying one payload item
interface awc_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/awc_mover.sv =====
// word mover: backing memory and line-word store, copies a line either way
module awc_mover (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  awc_pkg::move_t      mv_i,
  output logic                busy_o,
  // single-word access from the controller (only while idle)
  input  logic                acc_en_i,
  input  logic                acc_we_i,
  input  logic [awc_pkg::LwAw-1:0]  acc_addr_i,
  input  logic [awc_pkg::WordW-1:0] acc_wdata_i,
  output logic [awc_pkg::WordW-1:0] acc_rdata_o
);
  import awc_pkg::*;
  `include "assoc_writeback_lru_cache_core_defines.svh"

  logic [WordW-1:0] mem_q [MemWords];
  logic [WordW-1:0] lw_q  [NumLines*WordsPerLine];

  logic             busy_q, busy_d;
  logic             dir_q, dir_d;
  logic [LineW-1:0] line_q, line_d;
  logic [TagW-1:0]  tag_q, tag_d;
  logic [CntW-1:0]  rd_q, rd_d;     // words read so far
  logic [CntW-1:0]  n_q, n_d;
  logic             wv_q;           // read data of previous cycle valid
  logic [CntW-1:0]  widx_q;
  logic [WordW-1:0] mem_rd_q, lw_rd_q;
  logic             clr_q;
  logic [MemAw:0]   clr_cnt_q;

  logic [MemAw-1:0] mem_base, mem_raddr, mem_waddr;
  logic [LwAw-1:0]  lw_base, lw_raddr, lw_waddr;
  logic             rd_en;

  assign mem_base  = MemAw'(int'(tag_q) * WordsPerLine);
  assign lw_base   = LwAw'(int'(line_q) * WordsPerLine);
  assign mem_raddr = mem_base + MemAw'(rd_q);
  assign lw_raddr  = lw_base + LwAw'(rd_q);
  assign mem_waddr = mem_base + MemAw'(widx_q);
  assign lw_waddr  = lw_base + LwAw'(widx_q);
  assign rd_en     = busy_q && (rd_q < n_q);
  assign busy_o    = busy_q || clr_q;

  // sequencer: one word read per cycle, written in the cycle after its read
  always_comb begin
    busy_d = busy_q;
    dir_d  = dir_q;
    line_d = line_q;
    tag_d  = tag_q;
    rd_d   = rd_q;
    n_d    = n_q;
    if (!busy_q && mv_i.start) begin
      busy_d = 1'b1;
      dir_d  = mv_i.to_mem;
      line_d = mv_i.line;
      tag_d  = mv_i.tag;
      rd_d   = '0;
      n_d    = words_in_line(mv_i.tag);
    end else if (busy_q) begin
      if (rd_en) rd_d = rd_q + 1'b1;
      else if (!wv_q) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      dir_q     <= 1'b0;
      line_q    <= '0;
      tag_q     <= '0;
      rd_q      <= '0;
      n_q       <= '0;
      wv_q      <= 1'b0;
      widx_q    <= '0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      dir_q  <= dir_d;
      line_q <= line_d;
      tag_q  <= tag_d;
      rd_q   <= rd_d;
      n_q    <= n_d;
      wv_q   <= rd_en;
      widx_q <= rd_q;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == (MemAw+1)'(MemWords - 1)) clr_q <= 1'b0;
      end
    end
  end

  // backing memory: clearing pass, else read/write ports
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_cnt_q[MemAw-1:0]] <= '0;
    end else if (wv_q && dir_q) begin
      mem_q[mem_waddr] <= lw_rd_q;
    end
    mem_rd_q <= mem_q[mem_raddr];
  end

  // line-word store
  logic [LwAw-1:0] lw_ra;
  assign lw_ra = busy_q ? lw_raddr : acc_addr_i;
  always_ff @(posedge clk_i) begin
    if (wv_q && !dir_q) begin
      lw_q[lw_waddr] <= mem_rd_q;
    end else if (acc_en_i && acc_we_i) begin
      lw_q[acc_addr_i] <= acc_wdata_i;
    end
    lw_rd_q <= lw_q[lw_ra];
  end
  assign acc_rdata_o = lw_rd_q;

  `AWC_ASSERT(a_no_start_busy, clk_i, rst_ni, !(mv_i.start && busy_o), "mover start while busy")
  `AWC_ASSERT(a_no_acc_busy, clk_i, rst_ni, !(acc_en_i && busy_o), "word access while busy")
  `AWC_ASSERT(a_rd_bound, clk_i, rst_ni, rd_q <= n_q, "mover read count overrun")
endmodule

// ===== rtl/core/assoc_writeback_lru_cache_core.sv =====
// Fully associative write-back LRU cache (5 lines of 10 words) over a 128-word
// internal memory, one item at a time. After reset the backing memory is cleared,
// during which no item is accepted. A read hit passes through the access and read
// states, a write hit through the access state only. A miss fills the line through
// the mover, which copies one word per cycle through registered-read memories; a
// dirty victim adds its write-back first. A flush writes back each dirty line and
// steps over each clean line. The next item is accepted at the earliest in the
// cycle after the result is taken.
module assoc_writeback_lru_cache_core (
  input  logic clk_i,
  input  logic rst_ni,
  awc_if.sink   req_i,
  awc_if.source rsp_o
);
  import awc_pkg::*;
  `include "assoc_writeback_lru_cache_core_defines.svh"

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StWb     = 3'd1;
  localparam logic [2:0] StFill   = 3'd2;
  localparam logic [2:0] StLoad   = 3'd3;
  localparam logic [2:0] StAcc    = 3'd4;
  localparam logic [2:0] StRd     = 3'd5;
  localparam logic [2:0] StFlush  = 3'd6;
  localparam logic [2:0] StFlWait = 3'd7;

  logic [2:0]          st_q, st_d;
  logic [NumLines-1:0] valid_q, dirty_q;
  logic [TagW-1:0]     tag_q  [NumLines];
  logic [RankW-1:0]    rank_q [NumLines];
  logic [RankW-1:0]    rank_d [NumLines];
  logic                we_q;
  logic [WordW-1:0]    wdata_q;
  logic [TagW-1:0]     rtag_q, wbtag_q;
  logic [OffW-1:0]     roff_q;
  logic [LineW-1:0]    line_q;
  logic [LineW-1:0]    fl_q;
  logic                out_v_q;
  rsp_t                out_q;
  rsp_t                acc_rsp;
  move_t               mv;
  logic                mv_busy;
  logic                acc_en, acc_we;
  logic [LwAw-1:0]     acc_addr;
  logic [WordW-1:0]    acc_rdata;

  awc_mover u_mover (
    .clk_i, .rst_ni, .mv_i(mv), .busy_o(mv_busy),
    .acc_en_i(acc_en), .acc_we_i(acc_we), .acc_addr_i(acc_addr),
    .acc_wdata_i(wdata_q), .acc_rdata_o(acc_rdata)
  );

  // tag and offset split of the incoming address (reciprocal multiply)
  logic [MemAw-1:0] in_addr, in_base;
  logic [ProdW-1:0] in_prod;
  logic [TagW-1:0]  in_tag;
  logic [OffW-1:0]  in_off;
  logic             in_rw, in_ok;
  assign in_addr = req_i.data.address[MemAw-1:0];
  assign in_prod = ProdW'(in_addr) * ProdW'(TagRecip);
  assign in_tag  = TagW'(in_prod >> TagShift);
  assign in_base = MemAw'(int'(in_tag) * WordsPerLine);
  assign in_off  = OffW'(in_addr - in_base);
  assign in_rw   = (req_i.data.operation == OpRead) || (req_i.data.operation == OpWrite);
  assign in_ok   = req_i.data.address[AddrW-1:MemAw] == '0;

  // lookup and victim choice
  logic             lk_hit;
  logic [LineW-1:0] lk_line, inv_line, lru_line;
  logic             any_inv;
  always_comb begin
    lk_hit = 1'b0; lk_line = '0; any_inv = 1'b0; inv_line = '0; lru_line = '0;
    for (int i = NumLines-1; i >= 0; i--) begin
      if (valid_q[i] && tag_q[i] == in_tag) begin lk_hit = 1'b1; lk_line = LineW'(i); end
      if (!valid_q[i]) begin any_inv = 1'b1; inv_line = LineW'(i); end
    end
    for (int i = 1; i < NumLines; i++)
      if (rank_q[i] > rank_q[lru_line]) lru_line = LineW'(i);
  end

  logic accept;
  assign req_i.ready = (st_q == StIdle) && !out_v_q && !mv_busy;
  assign accept = req_i.valid && req_i.ready;
  assign rsp_o.valid = out_v_q;
  assign rsp_o.data  = out_q;
  assign acc_addr = LwAw'(int'(line_q) * WordsPerLine + int'(roff_q));
  assign acc_en = (st_q == StAcc);
  assign acc_we = we_q;

  logic [LineW-1:0] v_line, t_line;
  assign v_line = any_inv ? inv_line : lru_line;
  assign t_line = lk_hit ? lk_line : v_line;

  // recency ranks after touching the addressed line
  always_comb begin
    for (int i = 0; i < NumLines; i++) begin
      rank_d[i] = rank_q[i];
      if (LineW'(i) == t_line) rank_d[i] = '0;
      else if (valid_q[i] && (!valid_q[t_line] || rank_q[i] < rank_q[t_line]))
        rank_d[i] = rank_q[i] + 1'b1;
    end
  end

  // result fields known at accept time
  always_comb begin
    acc_rsp = '0;
    if (in_rw) begin
      if (!in_ok) acc_rsp.out_of_range = 1'b1;
      else if (lk_hit) begin
        acc_rsp.hit   = 1'b1;
        acc_rsp.delay = HitDelay;
      end else begin
        acc_rsp.delay = MissDelay;
      end
    end
  end

  // controller next state and mover requests
  always_comb begin
    st_d = st_q;
    mv = '0;
    case (st_q)
      StIdle: begin
        if (accept) begin
          if (req_i.data.operation == OpFlush) st_d = StFlush;
          else if (in_rw && in_ok) begin
            if (lk_hit) st_d = StAcc;
            else if (valid_q[v_line] && dirty_q[v_line]) st_d = StWb;
            else st_d = StFill;
          end
        end
      end
      StWb: if (!mv_busy) begin
        mv = '{start: 1'b1, to_mem: 1'b1, line: line_q, tag: wbtag_q};
        st_d = StFill;
      end
      StFill: if (!mv_busy) begin
        mv = '{start: 1'b1, to_mem: 1'b0, line: line_q, tag: rtag_q};
        st_d = StLoad;
      end
      StLoad: if (!mv_busy) st_d = StAcc;
      StAcc: st_d = we_q ? StIdle : StRd;
      StRd: st_d = StIdle;
      StFlush: begin
        if (valid_q[fl_q] && dirty_q[fl_q]) begin
          if (!mv_busy) begin
            mv = '{start: 1'b1, to_mem: 1'b1, line: fl_q, tag: tag_q[fl_q]};
            st_d = StFlWait;
          end
        end else if (fl_q == LineW'(NumLines-1)) begin
          st_d = StIdle;
        end
      end
      StFlWait: if (!mv_busy) st_d = (fl_q == LineW'(NumLines-1)) ? StIdle : StFlush;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; valid_q <= '0; dirty_q <= '0; out_v_q <= 1'b0; out_q <= '0;
      fl_q <= '0; line_q <= '0; we_q <= 1'b0; wdata_q <= '0;
      rtag_q <= '0; wbtag_q <= '0; roff_q <= '0;
      for (int i = 0; i < NumLines; i++) begin tag_q[i] <= '0; rank_q[i] <= '0; end
    end else begin
      st_q <= st_d;
      // result shown when an item finishes, held until taken
      if ((accept || st_q != StIdle) && st_d == StIdle) out_v_q <= 1'b1;
      else if (rsp_o.valid && rsp_o.ready) out_v_q <= 1'b0;
      if (accept) begin
        we_q    <= req_i.data.operation == OpWrite;
        wdata_q <= req_i.data.write_data;
        rtag_q  <= in_tag;
        roff_q  <= in_off;
        wbtag_q <= tag_q[v_line];
        line_q  <= t_line;
        fl_q    <= '0;
        out_q   <= acc_rsp;
        if (in_rw && in_ok) begin
          for (int i = 0; i < NumLines; i++) rank_q[i] <= rank_d[i];
          if (!lk_hit) begin
            valid_q[v_line] <= 1'b1;
            dirty_q[v_line] <= 1'b0;
            tag_q[v_line]   <= in_tag;
          end
        end
      end
      // flush walk over the lines
      if (st_q == StFlush && st_d == StFlWait) dirty_q[fl_q] <= 1'b0;
      if (st_q == StFlush && !(valid_q[fl_q] && dirty_q[fl_q]) &&
          fl_q != LineW'(NumLines-1)) fl_q <= fl_q + 1'b1;
      if (st_q == StFlWait && !mv_busy && fl_q != LineW'(NumLines-1)) fl_q <= fl_q + 1'b1;
      if (st_q == StAcc && we_q) dirty_q[line_q] <= 1'b1;
      if (st_q == StRd) out_q.read_data <= acc_rdata;
    end
  end

  `AWC_ASSERT(a_rsp_idle, clk_i, rst_ni, !(out_v_q && st_q != StIdle), "result shown while busy")
  `AWC_ASSERT_NEXT(a_acc_once, clk_i, rst_ni, st_q == StAcc, st_q != StAcc, "access state repeated")
  `AWC_ASSERT(a_no_accept_busy, clk_i, rst_ni, !(accept && mv_busy), "item taken while mover busy")
  `AWC_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_o.valid && !rsp_o.ready, rsp_o.valid, "result dropped")
endmodule
